// ----- src/tcfo_pkg.sv -----
// Shared types, constants and helper functions for the timecode offset block.
package tcfo_pkg;

  // Register map: 32-bit registers on a 4-byte stride.
  localparam int PADDR_W     = 3;
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_RATE_CODE    = 1'b0;
  localparam logic REG_FRAME_OFFSET = 1'b1;

  // Rate codes as written to the rate_code register.
  localparam logic [2:0] RATE_24     = 3'd0;
  localparam logic [2:0] RATE_25     = 3'd1;
  localparam logic [2:0] RATE_DF     = 3'd2;
  localparam logic [2:0] RATE_30     = 3'd3;
  localparam logic [2:0] RATE_23976  = 3'd4;
  localparam logic [2:0] RATE_2997ND = 3'd5;
  localparam logic [2:0] RATE_RESET  = RATE_25;

  // Pipeline depth: input register through output register.
  localparam int NSTG = 12;

  // Day lengths in frames.
  localparam logic [21:0] DAY_24 = 22'(24 * 3600 * 24);
  localparam logic [21:0] DAY_25 = 22'(24 * 3600 * 25);
  localparam logic [21:0] DAY_30 = 22'(24 * 3600 * 30);
  localparam logic [21:0] DAY_DF = 22'(24 * 3600 * 30 - 2 * 24 * 54);

  // Drop-frame structure.
  localparam int DF_TEN_MIN   = 17982;
  localparam int DF_FIRST_MIN = 1800;
  localparam int DF_OTHER_MIN = 1798;
  localparam int DF_HOUR      = 3600 * 30 - 2 * 54;

  // Reciprocals for divide-by-constant: floor(2^shift / divisor).
  localparam int DIV1_SHIFT = 22;
  localparam logic [11:0] RCP1_24 = 12'((1 << DIV1_SHIFT) / (60 * 24));
  localparam logic [11:0] RCP1_25 = 12'((1 << DIV1_SHIFT) / (60 * 25));
  localparam logic [11:0] RCP1_30 = 12'((1 << DIV1_SHIFT) / (60 * 30));
  localparam logic [11:0] RCP1_DF = 12'((1 << DIV1_SHIFT) / DF_TEN_MIN);
  localparam int SMALL_SHIFT = 11;
  localparam logic [5:0] HOUR_RCP = 6'((1 << SMALL_SHIFT) / 60);
  localparam logic [6:0] RCPS_24  = 7'((1 << SMALL_SHIFT) / 24);
  localparam logic [6:0] RCPS_25  = 7'((1 << SMALL_SHIFT) / 25);
  localparam logic [6:0] RCPS_30  = 7'((1 << SMALL_SHIFT) / 30);

  typedef enum logic [1:0] {
    MODE_24,
    MODE_25,
    MODE_30,
    MODE_DF
  } mode_t;

  typedef struct packed {
    logic [2:0]  rate_code;
    logic [22:0] frame_offset;
  } tcfo_cfg_t;

  function automatic mode_t mode_of(input logic [2:0] code);
    mode_t m;
    case (code)
      RATE_24, RATE_23976: m = MODE_24;
      RATE_30, RATE_2997ND: m = MODE_30;
      RATE_DF: m = MODE_DF;
      default: m = MODE_25;
    endcase
    return m;
  endfunction

  function automatic logic [21:0] day_of(input mode_t m);
    logic [21:0] d;
    case (m)
      MODE_24: d = DAY_24;
      MODE_30: d = DAY_30;
      MODE_DF: d = DAY_DF;
      default: d = DAY_25;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] fps_of(input mode_t m);
    logic [4:0] f;
    case (m)
      MODE_24: f = 5'd24;
      MODE_30, MODE_DF: f = 5'd30;
      default: f = 5'd25;
    endcase
    return f;
  endfunction

  // Frames per hour weight of the hours field.
  function automatic logic [16:0] fph_of(input mode_t m);
    logic [16:0] w;
    case (m)
      MODE_24: w = 17'(3600 * 24);
      MODE_30: w = 17'(3600 * 30);
      MODE_DF: w = 17'(DF_HOUR);
      default: w = 17'(3600 * 25);
    endcase
    return w;
  endfunction

  // Frames per minute weight of the minutes field.
  function automatic logic [10:0] fpm_of(input mode_t m);
    logic [10:0] w;
    case (m)
      MODE_24: w = 11'(60 * 24);
      MODE_30: w = 11'(60 * 30);
      MODE_DF: w = 11'(DF_OTHER_MIN);
      default: w = 11'(60 * 25);
    endcase
    return w;
  endfunction

  // Divisor of the first split: frames per minute, or per ten-minute block.
  function automatic logic [14:0] div1_of(input mode_t m);
    logic [14:0] d;
    case (m)
      MODE_24: d = 15'(60 * 24);
      MODE_30: d = 15'(60 * 30);
      MODE_DF: d = 15'(DF_TEN_MIN);
      default: d = 15'(60 * 25);
    endcase
    return d;
  endfunction

  function automatic logic [11:0] rcp1_of(input mode_t m);
    logic [11:0] r;
    case (m)
      MODE_24: r = RCP1_24;
      MODE_30: r = RCP1_30;
      MODE_DF: r = RCP1_DF;
      default: r = RCP1_25;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] rcps_of(input mode_t m);
    logic [6:0] r;
    case (m)
      MODE_24: r = RCPS_24;
      MODE_30, MODE_DF: r = RCPS_30;
      default: r = RCPS_25;
    endcase
    return r;
  endfunction

  // Tens digit of a minutes value below 60.
  function automatic logic [2:0] tens_of(input logic [5:0] mm);
    logic [2:0] cnt;
    cnt = 3'd0;
    for (int j = 1; j <= 5; j++) begin
      if (mm >= 6'(10 * j)) cnt = cnt + 3'd1;
    end
    return cnt;
  endfunction

  // Minute within a drop-frame ten-minute block, from the frame remainder.
  function automatic logic [3:0] mib_of(input logic [14:0] r);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int k = 0; k < 9; k++) begin
      if (r >= 15'(DF_FIRST_MIN + DF_OTHER_MIN * k)) cnt = cnt + 4'd1;
    end
    return cnt;
  endfunction

endpackage

// ----- src/tcfo_ifs.sv -----
// Valid/ready stream interfaces for incoming timecodes and offset results.
interface tcfo_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] in_hours;
  logic [5:0] in_minutes;
  logic [5:0] in_seconds;
  logic [4:0] in_frames;

  modport source (output valid, in_hours, in_minutes, in_seconds, in_frames,
                  input ready);
  modport sink   (input valid, in_hours, in_minutes, in_seconds, in_frames,
                  output ready);
endinterface

interface tcfo_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] out_hours;
  logic [5:0] out_minutes;
  logic [5:0] out_seconds;
  logic [4:0] out_frames;

  modport source (output valid, out_hours, out_minutes, out_seconds, out_frames,
                  input ready);
  modport sink   (input valid, out_hours, out_minutes, out_seconds, out_frames,
                  output ready);
endinterface

// ----- src/tcfo_regs.sv -----
// APB configuration registers: rate code and signed frame offset.
module tcfo_regs
  import tcfo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output tcfo_cfg_t          cfg
);

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate_code    <= RATE_RESET;
      cfg.frame_offset <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[REG_SEL_BIT])
        REG_RATE_CODE:    cfg.rate_code    <= pwdata[2:0];
        REG_FRAME_OFFSET: cfg.frame_offset <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_RATE_CODE:    prdata = {29'd0, cfg.rate_code};
      REG_FRAME_OFFSET: prdata = {{9{cfg.frame_offset[22]}}, cfg.frame_offset};
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- src/timecode_frame_offset.sv -----
// Top level: pipelined SMPTE timecode plus signed frame offset with day wrap.
//
// Usage
//   timecode : input stream of words (hours, minutes, seconds, frames), taken
//              at a clock edge where valid and ready are both high.
//   result   : output stream, one word per input word, in input order.
//   APB port : rate_code at 0x0, frame_offset (23-bit two's complement) at
//              0x4. Write only while the pipeline is empty.
// Timing
//   Twelve register stages. One word per cycle is taken and delivered
//   when the receiver keeps ready high. The depth is set by the day wrap
//   (four compare and subtract steps over three stages) and two
//   reciprocal-multiply dividers, each a multiply, a multiply-subtract and
//   a correction stage.
// Stall
//   Each stage holds its word while the next stage is full and blocked, so a
//   stall on result backs up stage by stage; empty stages still fill, and
//   timecode.ready drops only once every stage holds a word.
// Reset
//   rst is synchronous: all stage valid bits clear, timecode.ready is held
//   low, rate_code returns to 25 fps and frame_offset to zero.
module timecode_frame_offset
  import tcfo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  tcfo_in_if.sink            timecode,
  tcfo_out_if.source         result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  tcfo_cfg_t cfg;

  tcfo_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Mode consts; user, unchecked: configuration stable with words in flight.
  mode_t       mode;
  logic        df;
  logic [21:0] day;
  logic [4:0]  fps;
  logic [16:0] fph;
  logic [10:0] fpm;
  logic [14:0] div1;
  logic [11:0] rcp1;
  logic [6:0]  rcps;

  assign mode = mode_of(cfg.rate_code);
  assign df   = (mode == MODE_DF);
  assign day  = day_of(mode);
  assign fps  = fps_of(mode);
  assign fph  = fph_of(mode);
  assign fpm  = fpm_of(mode);
  assign div1 = div1_of(mode);
  assign rcp1 = rcp1_of(mode);
  assign rcps = rcps_of(mode);

  // Stage handshake: a stage loads when it is empty or its word moves on.
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || result.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign timecode.ready = adv[0] && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= timecode.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 0: in drop-frame, fold each field into its range and take the
  // tens digit of minutes (two frames come back per tenth minute).
  logic [4:0] h_n;
  logic [5:0] m_n;
  logic [5:0] s_n;
  logic [4:0] f_n;
  logic [2:0] tens_n;
  logic [4:0] s0_h;
  logic [5:0] s0_m;
  logic [5:0] s0_s;
  logic [4:0] s0_f;
  logic [2:0] s0_tens;

  assign h_n = (df && timecode.in_hours >= 5'd24) ? timecode.in_hours - 5'd24
                                                  : timecode.in_hours;
  assign m_n = (df && timecode.in_minutes >= 6'd60) ? timecode.in_minutes - 6'd60
                                                    : timecode.in_minutes;
  assign s_n = (df && timecode.in_seconds >= 6'd60) ? timecode.in_seconds - 6'd60
                                                    : timecode.in_seconds;
  assign f_n = (df && timecode.in_frames >= 5'd30) ? timecode.in_frames - 5'd30
                                                   : timecode.in_frames;
  assign tens_n = df ? tens_of(m_n) : 3'd0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_h    <= h_n;
      s0_m    <= m_n;
      s0_s    <= s_n;
      s0_f    <= f_n;
      s0_tens <= tens_n;
    end
  end

  // Stage 1: weighted frame count. Drop-frame weights are 1798 per minute
  // and 107892 per hour, plus two frames per tens digit of minutes.
  logic [21:0] count_c;
  logic [21:0] s1_count;

  assign count_c = 22'(s0_h) * 22'(fph) + 22'(s0_m) * 22'(fpm)
                 + 22'(s0_s) * 22'(fps) + 22'(s0_f) + 22'({s0_tens, 1'b0});

  always_ff @(posedge clk) begin
    if (adv[1]) s1_count <= count_c;
  end

  // Stage 2: add the offset and four days to stay positive, then start the
  // day wrap with the eight-day step.
  logic [25:0] sum_c;
  logic [24:0] v2_c;
  logic [24:0] day8;
  logic [24:0] s2_v;

  assign sum_c = 26'(s1_count) + {{3{cfg.frame_offset[22]}}, cfg.frame_offset}
               + 26'({day, 2'b00});
  assign v2_c  = sum_c[24:0];
  assign day8  = {day, 3'b000};

  always_ff @(posedge clk) begin
    if (adv[2]) s2_v <= (v2_c >= day8) ? v2_c - day8 : v2_c;
  end

  // Stage 3: four-day and two-day steps.
  logic [24:0] day4;
  logic [24:0] day2;
  logic [24:0] x3_c;
  logic [24:0] s3_v;

  assign day4 = {1'b0, day, 2'b00};
  assign day2 = {2'b00, day, 1'b0};
  assign x3_c = (s2_v >= day4) ? s2_v - day4 : s2_v;

  always_ff @(posedge clk) begin
    if (adv[3]) s3_v <= (x3_c >= day2) ? x3_c - day2 : x3_c;
  end

  // Stage 4: one-day step; the count is now inside the day.
  logic [24:0] day1;
  logic [24:0] z4_c;
  logic [21:0] s4_t;

  assign day1 = {3'b000, day};
  assign z4_c = (s3_v >= day1) ? s3_v - day1 : s3_v;

  always_ff @(posedge clk) begin
    if (adv[4]) s4_t <= z4_c[21:0];
  end

  // Stages 5-7: split into minutes (or ten-minute blocks in drop-frame) and
  // frames within. The reciprocal estimate is low by at most one.
  logic [33:0] prod1_c;
  logic [21:0] s5_t;
  logic [10:0] s5_qe;

  assign prod1_c = 34'(s4_t) * 34'(rcp1);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_t  <= s4_t;
      s5_qe <= prod1_c[DIV1_SHIFT+10:DIV1_SHIFT];
    end
  end

  logic [21:0] re6_c;
  logic [10:0] s6_q;
  logic [15:0] s6_r;

  assign re6_c = s5_t - 22'(s5_qe) * 22'(div1);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_q <= s5_qe;
      s6_r <= re6_c[15:0];
    end
  end

  logic        fix7_c;
  logic [15:0] r7_c;
  logic [10:0] s7_q;
  logic [14:0] s7_r;

  assign fix7_c = (s6_r >= 16'(div1));
  assign r7_c   = fix7_c ? s6_r - 16'(div1) : s6_r;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_q <= fix7_c ? s6_q + 11'd1 : s6_q;
      s7_r <= r7_c[14:0];
    end
  end

  // Stage 8: in drop-frame, find the minute inside the ten-minute block;
  // later minutes drop two labels each, so the frame index is rem - 1798*k.
  logic [3:0]  mib_c;
  logic [13:0] mins_w;
  logic [14:0] idx_w;
  logic [10:0] s8_mins;
  logic [10:0] s8_idx;

  assign mib_c  = df ? mib_of(s7_r) : 4'd0;
  assign mins_w = {s7_q, 3'b000} + {2'b00, s7_q, 1'b0} + 14'(mib_c);
  assign idx_w  = s7_r - 15'(mib_c) * 15'(DF_OTHER_MIN);

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s8_mins <= df ? mins_w[10:0] : s7_q;
      s8_idx  <= idx_w[10:0];
    end
  end

  // Stages 9-11: hours/minutes from the minute count, seconds/frames from
  // the frame index, both by reciprocal estimate and one correction.
  logic [15:0] hprod_c;
  logic [17:0] sprod_c;
  logic [10:0] s9_mins;
  logic [10:0] s9_idx;
  logic [4:0]  s9_hq;
  logic [5:0]  s9_sq;

  assign hprod_c = 16'(s8_mins) * 16'(HOUR_RCP);
  assign sprod_c = 18'(s8_idx) * 18'(rcps);

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      s9_mins <= s8_mins;
      s9_idx  <= s8_idx;
      s9_hq   <= hprod_c[SMALL_SHIFT+4:SMALL_SHIFT];
      s9_sq   <= sprod_c[SMALL_SHIFT+5:SMALL_SHIFT];
    end
  end

  logic [10:0] mre_c;
  logic [10:0] fre_c;
  logic [4:0]  s10_hq;
  logic [5:0]  s10_sq;
  logic [6:0]  s10_mre;
  logic [5:0]  s10_fre;

  assign mre_c = s9_mins - 11'(s9_hq) * 11'(60);
  assign fre_c = s9_idx - 11'(s9_sq) * 11'(fps);

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      s10_hq  <= s9_hq;
      s10_sq  <= s9_sq;
      s10_mre <= mre_c[6:0];
      s10_fre <= fre_c[5:0];
    end
  end

  logic       hfix_c;
  logic       sfix_c;
  logic [4:0] s11_h;
  logic [5:0] s11_m;
  logic [5:0] s11_s;
  logic [4:0] s11_f;

  assign hfix_c = (s10_mre >= 7'd60);
  assign sfix_c = (s10_fre >= 6'(fps));

  // Output register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (adv[11]) begin
      s11_h <= hfix_c ? s10_hq + 5'd1 : s10_hq;
      s11_m <= hfix_c ? 6'(s10_mre - 7'd60) : s10_mre[5:0];
      s11_s <= sfix_c ? s10_sq + 6'd1 : s10_sq;
      s11_f <= sfix_c ? 5'(s10_fre - 6'(fps)) : s10_fre[4:0];
    end
  end

  assign result.valid       = vld[NSTG-1];
  assign result.out_hours   = s11_h;
  assign result.out_minutes = s11_m;
  assign result.out_seconds = s11_s;
  assign result.out_frames  = s11_f;

  // Checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_day_wrap: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (s4_t < day))
    else $error("wrapped count not inside the day");

  a_split_rem: assert property (@(posedge clk) disable iff (rst)
    vld[7] |-> (s7_r < div1))
    else $error("first split remainder not below divisor");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.out_hours <= 5'd23) && (result.out_minutes <= 6'd59)
                     && (result.out_seconds <= 6'd59) && (result.out_frames < fps))
    else $error("result field out of range");

endmodule

// ----- verif/timecode_frame_offset_tb.sv -----
// Self-checking testbench for the timecode frame offset block.
`timescale 1ns / 100ps

module timecode_frame_offset_tb;
  import tcfo_pkg::*;

  // Raw timecode as carried by both streams.
  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] frames;
  } timecode_t;

  // Idle and stall profiles for the two stream sides.
  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_STALL,
    IDLE_BOTH
  } idle_mode_t;

  // Unassigned rate codes, counted as 25 fps.
  localparam logic [2:0] RATE_SPARE6 = 3'd6;
  localparam logic [2:0] RATE_SPARE7 = 3'd7;

  localparam int  CYCLE_LIMIT   = 200_000;
  localparam int  PHASES        = 16;
  localparam int  WORDS_PER_RUN = 30;
  localparam longint OFFSET_MAX = 2592000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  tcfo_in_if  tc_if ();
  tcfo_out_if res_if ();

  timecode_frame_offset uut (
    .clk      (clk),
    .rst      (rst),
    .timecode (tc_if.sink),
    .result   (res_if.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Words waiting to be sent, and offset timecodes waiting to come back.
  timecode_t pending_codes[$];
  timecode_t expected_codes[$];

  // Testbench copy of the two registers.
  logic [2:0] cur_rate   = RATE_RESET;
  longint     cur_offset = 0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int errors        = 0;
  int checked       = 0;
  int cycles        = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offset one timecode and wrap it over the day at the given rate.
  function automatic timecode_t offset_timecode(timecode_t tc, logic [2:0] rate,
                                                longint ofs);
    longint fps, day, t, hh, mm, ss, ff, mins, rem, r2, mib, idx;
    timecode_t r;
    if (rate == RATE_DF) begin
      // Reduce each field first, then drop two labels per non-tenth minute.
      hh   = longint'(tc.hours) % 24;
      mm   = longint'(tc.minutes) % 60;
      ss   = longint'(tc.seconds) % 60;
      ff   = longint'(tc.frames) % 30;
      mins = hh * 60 + mm;
      t    = (hh * 3600 + mm * 60 + ss) * 30 + ff - 2 * (mins - mins / 10) + ofs;
      day  = longint'(DAY_DF);
      t    = t % day;
      if (t < 0) t += day;
      rem = t % DF_TEN_MIN;
      if (rem < DF_FIRST_MIN) begin
        mib = 0;
        idx = rem;
      end else begin
        r2  = rem - DF_FIRST_MIN;
        mib = 1 + r2 / DF_OTHER_MIN;
        idx = r2 % DF_OTHER_MIN + 2;
      end
      mins      = (t / DF_TEN_MIN) * 10 + mib;
      r.hours   = 5'((mins / 60) % 24);
      r.minutes = 6'(mins % 60);
      r.seconds = 6'(idx / 30);
      r.frames  = 5'(idx % 30);
    end else begin
      case (rate)
        RATE_24, RATE_23976: fps = 24;
        RATE_30, RATE_2997ND: fps = 30;
        default: fps = 25;
      endcase
      // Raw fields, no range check: form the count, add, wrap.
      day = 24 * 3600 * fps;
      t   = (longint'(tc.hours) * 3600 + longint'(tc.minutes) * 60
             + longint'(tc.seconds)) * fps + longint'(tc.frames) + ofs;
      t   = t % day;
      if (t < 0) t += day;
      r.hours   = 5'(t / (3600 * fps));
      t         = t % (3600 * fps);
      r.minutes = 6'(t / (60 * fps));
      t         = t % (60 * fps);
      r.seconds = 6'(t / fps);
      r.frames  = 5'(t % fps);
    end
    return r;
  endfunction

  // APB write: setup cycle, access cycle; the register takes the word at the
  // edge that closes the access cycle.
  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(reg_idx) << REG_SEL_BIT;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_RATE_CODE) begin
      cur_rate = value[2:0];
    end else begin
      cur_offset = longint'($signed(value[22:0]));
    end
  endtask

  task automatic configure(input logic [2:0] rate, input longint ofs);
    write_reg(REG_RATE_CODE, 32'(rate));
    write_reg(REG_FRAME_OFFSET, 32'(ofs));
  endtask

  task automatic queue_timecode(input int h, input int m, input int s, input int f);
    timecode_t tc;
    tc.hours   = 5'(h);
    tc.minutes = 6'(m);
    tc.seconds = 6'(s);
    tc.frames  = 5'(f);
    pending_codes.push_back(tc);
  endtask

  // Hold until every word is sent and every result is back, then let the
  // pipeline settle before the registers are touched again.
  task automatic drain;
    do @(posedge clk);
    while (pending_codes.size() != 0 || tc_if.valid || expected_codes.size() != 0);
    repeat (NSTG + 4) @(posedge clk);
  endtask

  // Sender: record each accepted word's expected result, then offer the next
  // word or idle, advancing only when the current word has been taken.
  always @(posedge clk) begin : drive_timecode
    timecode_t sent;
    timecode_t word;
    if (rst) begin
      tc_if.valid      <= 1'b0;
      tc_if.in_hours   <= '0;
      tc_if.in_minutes <= '0;
      tc_if.in_seconds <= '0;
      tc_if.in_frames  <= '0;
    end else begin
      if (tc_if.valid && tc_if.ready) begin
        sent.hours   = tc_if.in_hours;
        sent.minutes = tc_if.in_minutes;
        sent.seconds = tc_if.in_seconds;
        sent.frames  = tc_if.in_frames;
        expected_codes.push_back(offset_timecode(sent, cur_rate, cur_offset));
      end
      if (!tc_if.valid || tc_if.ready) begin
        if (pending_codes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          word = pending_codes.pop_front();
          tc_if.valid      <= 1'b1;
          tc_if.in_hours   <= word.hours;
          tc_if.in_minutes <= word.minutes;
          tc_if.in_seconds <= word.seconds;
          tc_if.in_frames  <= word.frames;
        end else begin
          tc_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each result word against the oldest expectation, then
  // drop or raise ready at random for the next cycle.
  always @(posedge clk) begin : check_result
    timecode_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_codes.size() == 0) begin
          $error("result word %0d:%0d:%0d:%0d with no timecode outstanding",
                 res_if.out_hours, res_if.out_minutes, res_if.out_seconds,
                 res_if.out_frames);
          errors++;
        end else begin
          want = expected_codes.pop_front();
          checked++;
          if (res_if.out_hours !== want.hours) begin
            $error("out_hours: expected %0d, got %0d", want.hours, res_if.out_hours);
            errors++;
          end
          if (res_if.out_minutes !== want.minutes) begin
            $error("out_minutes: expected %0d, got %0d", want.minutes, res_if.out_minutes);
            errors++;
          end
          if (res_if.out_seconds !== want.seconds) begin
            $error("out_seconds: expected %0d, got %0d", want.seconds, res_if.out_seconds);
            errors++;
          end
          if (res_if.out_frames !== want.frames) begin
            $error("out_frames: expected %0d, got %0d", want.frames, res_if.out_frames);
            errors++;
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycles, expected_codes.size());
      $display("** timecode_frame_offset: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic [2:0] phase_rate[PHASES] = '{RATE_DF, RATE_24, RATE_25, RATE_30, RATE_23976,
                                       RATE_2997ND, RATE_SPARE6, RATE_SPARE7, RATE_DF,
                                       RATE_30, RATE_24, RATE_DF, RATE_25, RATE_2997ND,
                                       RATE_DF, RATE_23976};
    longint ofs;
    int     cat;
    int     n_words;

    // Drive the configuration inputs to a known value from time zero.
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings (25 fps, no offset): field extremes and raw overflow.
    queue_timecode(0, 0, 0, 0);
    queue_timecode(23, 59, 59, 24);
    queue_timecode(31, 63, 63, 31);
    queue_timecode(24, 0, 0, 0);
    queue_timecode(0, 0, 0, 25);
    drain();

    // Drop-frame, one frame back: negative wrap, skipped labels at the top
    // of a non-tenth minute, tenth-minute boundary, field reduction.
    configure(RATE_DF, -1);
    queue_timecode(0, 0, 0, 0);
    queue_timecode(0, 1, 0, 0);
    queue_timecode(0, 1, 0, 1);
    queue_timecode(0, 10, 0, 0);
    queue_timecode(0, 9, 59, 29);
    queue_timecode(23, 59, 59, 29);
    queue_timecode(31, 63, 63, 31);
    queue_timecode(24, 60, 60, 30);
    drain();

    // Offset extremes at other rates.
    configure(RATE_30, OFFSET_MAX);
    queue_timecode(0, 0, 0, 0);
    queue_timecode(23, 59, 59, 29);
    drain();
    configure(RATE_24, -OFFSET_MAX);
    queue_timecode(0, 0, 0, 0);
    queue_timecode(23, 59, 59, 23);
    drain();

    // Random phases: each with its own rate, offset and idle profile.
    for (int k = 0; k < PHASES; k++) begin
      case (k % 4)
        0: ofs = (k % 8 == 0) ? -OFFSET_MAX : OFFSET_MAX;
        1: ofs = 0;
        2: ofs = longint'($urandom_range(2 * OFFSET_MAX)) - OFFSET_MAX;
        default: ofs = longint'($urandom_range(10000)) - 5000;
      endcase
      configure(phase_rate[k], ofs);

      case (idle_mode_t'(k % 4))
        IDLE_NONE: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        IDLE_SEND: begin
          send_idle_pct = 75;
          stall_pct     = 0;
        end
        IDLE_STALL: begin
          send_idle_pct = 0;
          stall_pct     = 75;
        end
        default: begin
          send_idle_pct = 17;
          stall_pct     = 17;
        end
      endcase

      n_words = WORDS_PER_RUN;
      for (int i = 0; i < n_words; i++) begin
        cat = $urandom_range(9);
        if (cat <= 6) begin
          // Hours, minutes and seconds in range, frames up to the drop-frame label range.
          queue_timecode($urandom_range(23), $urandom_range(59), $urandom_range(59),
                         $urandom_range(29));
        end else if (cat == 7) begin
          // Minute and day edges, where labels are skipped or days wrap.
          queue_timecode($urandom_range(1) ? 23 : 0, $urandom_range(59),
                         $urandom_range(1) ? 59 : 0,
                         $urandom_range(1) ? $urandom_range(1) : 28 + $urandom_range(1));
        end else begin
          // Raw field bits, out of range allowed.
          queue_timecode($urandom_range(31), $urandom_range(63), $urandom_range(63),
                         $urandom_range(31));
        end
      end
      drain();
    end

    $display("checked %0d offset timecodes over %0d register settings,", checked,
             PHASES + 4);
    $display("all eight rate codes, offset extremes and four idle/stall profiles");
    if (errors == 0) begin
      $display("** timecode_frame_offset: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** timecode_frame_offset: FAILED **");
    end
    $finish;
  end

endmodule
